// ===== rtl/hbfh_pkg.sv =====
// ----------------------------------------------------------------------------
// hbfh_pkg
// Shared types, constants and helpers of the harmonic bond force unit.
// ----------------------------------------------------------------------------
package hbfh_pkg;

  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 24;

  localparam int CRD_W  = 32;
  localparam int PRM_W  = 31;
  localparam int RES_W  = 48;
  localparam int ENG_W  = 47;
  localparam int IDATA_W = 256;
  localparam int ODATA_W = 336;
  localparam int ADDR_W = 5;

  localparam int CNT_W         = 7;
  localparam int MUL_LAST      = 4;
  localparam int SQRT_LAST     = 32;
  localparam int DIV_SAT_BITS  = 47;
  localparam int DIV_FULL_BITS = 64;

  localparam logic [ENG_W-1:0] MAX47 = '1;
  localparam logic [63:0]      LIM62 = 64'h4000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_BOX_X  = 3'd0,
    REG_BOX_Y  = 3'd1,
    REG_BOX_Z  = 3'd2,
    REG_HALF_X = 3'd3,
    REG_HALF_Y = 3'd4,
    REG_HALF_Z = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_WRAP,
    S_CLAMP,
    S_R2,
    S_SQRT,
    S_DT,
    S_E_MUL,
    S_E_MUL2,
    S_E_ACC,
    S_P2,
    S_DE_DIV,
    S_DE_SET,
    S_C_CALC,
    S_H_SQ,
    S_H_MUL,
    S_H_DIV,
    S_H_ACC,
    S_F_MUL,
    S_F_DIV,
    S_F_SET,
    S_FIN
  } state_e;

  // shift left for sh >= 0, right (truncating) otherwise
  function automatic logic [127:0] shift128(input logic [127:0] v, input int sh);
    logic [127:0] r;
    if (sh >= 0) begin
      r = v << sh;
    end else begin
      r = v >> (-sh);
    end
    return r;
  endfunction

endpackage

// ===== rtl/harmonic_bond_force_hessian_top.sv =====
// ----------------------------------------------------------------------------
// harmonic_bond_force_hessian_top
// Harmonic bond force, energy and Hessian diagonal with minimum-image wrap.
// ----------------------------------------------------------------------------
// One bond item is taken when the block is idle and processed by a small
// sequencer over a shared 32x32 multiplier, a one-bit-per-cycle square root
// and a one-bit-per-cycle divider. For a bond of nonzero length, the time from
// acceptance to result is set mostly by the divider (one division
// of 47 quotient bits for the scale term and, per axis, one of 64 bits for
// the Hessian and one of 47 bits for the force); a bond of zero length skips
// all divisions. The result waits in an output register, and the next bond
// is taken as soon as the block is idle again. Energy restarts from zero after
// a bond marked last; Hessian sums run until reset.
// ----------------------------------------------------------------------------
module harmonic_bond_force_hessian_top #(
  parameter int IN_FRAC_BITS  = hbfh_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = hbfh_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 each),
  // rest_length (31), stiffness (31), zero pad (2)
  input  logic [hbfh_pkg::IDATA_W-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tlast_i,
  output logic                         s_axis_tready_o,
  // force_x, force_y, force_z (48 each), energy_total (47),
  // hess_total_x, hess_total_y, hess_total_z (48 each), zero pad (1)
  output logic [hbfh_pkg::ODATA_W-1:0] m_axis_tdata_o,
  // zero_length
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  output logic                         m_axis_tlast_o,
  input  logic                         m_axis_tready_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbfh_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hbfh_pkg::*;

  localparam int SH_E  = OUT_FRAC_BITS - 3 * IN_FRAC_BITS;
  localparam int SH_DE = OUT_FRAC_BITS - IN_FRAC_BITS;
  localparam int SH_F  = OUT_FRAC_BITS - 2 * IN_FRAC_BITS;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;

  logic [PRM_W-1:0] box_q [3];
  logic [PRM_W-1:0] box_d [3];
  logic [PRM_W-1:0] half_q [3];
  logic [PRM_W-1:0] half_d [3];

  logic signed [CRD_W-1:0] pa_q [3];
  logic signed [CRD_W-1:0] pa_d [3];
  logic signed [CRD_W-1:0] pb_q [3];
  logic signed [CRD_W-1:0] pb_d [3];
  logic [PRM_W-1:0] req_q, req_d, k_q, k_d;
  logic last_q, last_d;

  logic signed [34:0] dd_q [3];
  logic signed [34:0] dd_d [3];
  logic [PRM_W-1:0] ad_q [3];
  logic [PRM_W-1:0] ad_d [3];
  logic dneg_q [3];
  logic dneg_d [3];

  logic [63:0]  pp_q, pp_d;
  logic [1:0]   ppsh_q, ppsh_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  mul_a, mul_b;
  logic         mul_act, mul_done;

  logic [63:0] sx_q, sx_d, res_q, res_d, one_q, one_d, r2_q, r2_d;
  logic [31:0] r_q, r_d, adt_q, adt_d;
  logic dtneg_q, dtneg_d, zero_q, zero_d;
  logic [63:0] tmp_q, tmp_d, p2_q, p2_d;
  logic [ENG_W-1:0] energy_q, energy_d;

  logic [63:0]  dnum_q, dnum_d, drem_q, drem_d, dquo_q, dquo_d;
  logic         dsat_q, dsat_d;
  logic [127:0] div_src;
  logic [63:0]  div_den;
  logic         div_act, div_q64, div_last;
  logic [63:0]  dres47, dres62;

  logic signed [RES_W-1:0] de_q, de_d;
  logic [63:0] ac_q, ac_d;
  logic cneg_q, cneg_d;
  logic signed [RES_W-1:0] hacc_q [3];
  logic signed [RES_W-1:0] hacc_d [3];
  logic signed [RES_W-1:0] frc_q [3];
  logic signed [RES_W-1:0] frc_d [3];

  logic ov_q, ov_d, ouser_q, ouser_d, olast_q, olast_d;
  logic [ODATA_W-1:0] od_q, od_d;

  logic s_fire, out_free, cfg_we;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid_i && (state_q == S_IDLE);
  assign out_free = !ov_q || m_axis_tready_i;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;

  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = olast_q;

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[4:2]))
      REG_BOX_X:  prdata = {1'b0, box_q[0]};
      REG_BOX_Y:  prdata = {1'b0, box_q[1]};
      REG_BOX_Z:  prdata = {1'b0, box_q[2]};
      REG_HALF_X: prdata = {1'b0, half_q[0]};
      REG_HALF_Y: prdata = {1'b0, half_q[1]};
      REG_HALF_Z: prdata = {1'b0, half_q[2]};
      default:    prdata = '0;
    endcase
  end

  assign mul_done = (cnt_q == CNT_W'(MUL_LAST));
  assign div_q64  = (state_q == S_H_DIV);
  assign div_last = div_q64 ? (cnt_q == CNT_W'(DIV_FULL_BITS))
                            : (cnt_q == CNT_W'(DIV_SAT_BITS));

  // next state
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    cnt_d   = cnt_q + CNT_W'(1);
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (s_fire) state_d = S_DIFF;
      end
      S_DIFF:  state_d = S_WRAP;
      S_WRAP:  state_d = S_CLAMP;
      S_CLAMP: begin
        state_d = S_R2;
        ax_d    = '0;
      end
      S_R2: begin
        if (mul_done) begin
          if (ax_q == 2'd2) begin
            state_d = S_SQRT;
            ax_d    = '0;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_SQRT:   if (cnt_q == CNT_W'(SQRT_LAST)) state_d = S_DT;
      S_DT:     state_d = S_E_MUL;
      S_E_MUL:  if (mul_done) state_d = S_E_MUL2;
      S_E_MUL2: if (mul_done) state_d = S_E_ACC;
      S_E_ACC:  state_d = zero_q ? S_FIN : S_P2;
      S_P2:     if (mul_done) state_d = S_DE_DIV;
      S_DE_DIV: if (div_last) state_d = S_DE_SET;
      S_DE_SET: state_d = S_C_CALC;
      S_C_CALC: begin
        state_d = S_H_SQ;
        ax_d    = '0;
      end
      S_H_SQ:   if (mul_done) state_d = S_H_MUL;
      S_H_MUL:  if (mul_done) state_d = S_H_DIV;
      S_H_DIV:  if (div_last) state_d = S_H_ACC;
      S_H_ACC:  state_d = S_F_MUL;
      S_F_MUL:  if (mul_done) state_d = S_F_DIV;
      S_F_DIV:  if (div_last) state_d = S_F_SET;
      S_F_SET: begin
        if (ax_q == 2'd2) begin
          state_d = S_FIN;
        end else begin
          state_d = S_H_SQ;
          ax_d    = ax_q + 2'd1;
        end
      end
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if ((state_d != state_q) || (ax_d != ax_q)) cnt_d = '0;
  end

  // operand selection
  always_comb begin
    mul_act = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_R2: begin
        mul_a = 64'(ad_q[ax_q]);
        mul_b = 64'(ad_q[ax_q]);
      end
      S_E_MUL: begin
        mul_a = 64'(adt_q);
        mul_b = 64'(adt_q);
      end
      S_E_MUL2: begin
        mul_a = 64'(k_q);
        mul_b = tmp_q;
      end
      S_P2: begin
        mul_a = 64'(k_q);
        mul_b = 64'(adt_q);
      end
      S_H_SQ: begin
        mul_a = 64'(ad_q[ax_q]);
        mul_b = 64'(ad_q[ax_q]);
      end
      S_H_MUL: begin
        mul_a = ac_q;
        mul_b = tmp_q;
      end
      S_F_MUL: begin
        mul_a = p2_q;
        mul_b = 64'(ad_q[ax_q]);
      end
      default: mul_act = 1'b0;
    endcase
  end

  always_comb begin
    div_act = 1'b1;
    div_src = '0;
    div_den = '0;
    case (state_q)
      S_DE_DIV: begin
        div_src = shift128({64'b0, p2_q}, SH_DE);
        div_den = 64'(r_q);
      end
      S_H_DIV: begin
        div_src = acc_q;
        div_den = r2_q;
      end
      S_F_DIV: begin
        div_src = shift128(acc_q, SH_F);
        div_den = 64'(r_q);
      end
      default: div_act = 1'b0;
    endcase
  end

  assign dres47 = dsat_q ? 64'(MAX47) : dquo_q;
  assign dres62 = (dsat_q || (dquo_q > LIM62)) ? LIM62 : dquo_q;

  // datapath
  always_comb begin
    logic signed [34:0] half35, box35, cl;
    logic signed [34:0] ngv;
    logic [31:0]  ah, bh;
    logic [127:0] ppx;
    logic [63:0]  sq_t;
    logic signed [32:0] dt;
    logic [127:0] esh;
    logic [ENG_W-1:0] e;
    logic [ENG_W:0] esum;
    logic [127:0] hi, tk;
    logic [64:0]  dt65;
    logic signed [63:0] twok, c, sm, h, hs;

    for (int i = 0; i < 3; i++) begin
      box_d[i]  = box_q[i];
      half_d[i] = half_q[i];
      pa_d[i]   = pa_q[i];
      pb_d[i]   = pb_q[i];
      dd_d[i]   = dd_q[i];
      ad_d[i]   = ad_q[i];
      dneg_d[i] = dneg_q[i];
      hacc_d[i] = hacc_q[i];
      frc_d[i]  = frc_q[i];
    end
    req_d = req_q; k_d = k_q; last_d = last_q;
    pp_d = pp_q; ppsh_d = ppsh_q; acc_d = acc_q;
    sx_d = sx_q; res_d = res_q; one_d = one_q; r2_d = r2_q;
    r_d = r_q; adt_d = adt_q; dtneg_d = dtneg_q; zero_d = zero_q;
    tmp_d = tmp_q; p2_d = p2_q; energy_d = energy_q;
    dnum_d = dnum_q; drem_d = drem_q; dquo_d = dquo_q; dsat_d = dsat_q;
    de_d = de_q; ac_d = ac_q; cneg_d = cneg_q;
    ov_d = ov_q; od_d = od_q; ouser_d = ouser_q; olast_d = olast_q;
    half35 = '0; box35 = '0; cl = '0; ngv = '0;
    ah = '0; bh = '0; ppx = '0; sq_t = '0; dt = '0;
    esh = '0; e = '0; esum = '0; hi = '0; tk = '0; dt65 = '0;
    twok = '0; c = '0; sm = '0; h = '0; hs = '0;

    if (cfg_we) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_BOX_X:  box_d[0]  = pwdata[PRM_W-1:0];
        REG_BOX_Y:  box_d[1]  = pwdata[PRM_W-1:0];
        REG_BOX_Z:  box_d[2]  = pwdata[PRM_W-1:0];
        REG_HALF_X: half_d[0] = pwdata[PRM_W-1:0];
        REG_HALF_Y: half_d[1] = pwdata[PRM_W-1:0];
        REG_HALF_Z: half_d[2] = pwdata[PRM_W-1:0];
        default: ;
      endcase
    end

    if (ov_q && m_axis_tready_i) ov_d = 1'b0;

    if (s_fire) begin
      for (int i = 0; i < 3; i++) begin
        pa_d[i] = s_axis_tdata_i[CRD_W*i +: CRD_W];
        pb_d[i] = s_axis_tdata_i[CRD_W*(i+3) +: CRD_W];
      end
      req_d  = s_axis_tdata_i[192 +: PRM_W];
      k_d    = s_axis_tdata_i[223 +: PRM_W];
      last_d = s_axis_tlast_i;
    end

    // shared multiplier: issue partials at cnt 0..3, accumulate at 1..4
    if (mul_act) begin
      ah = cnt_q[1] ? mul_a[63:32] : mul_a[31:0];
      bh = cnt_q[0] ? mul_b[63:32] : mul_b[31:0];
      if (cnt_q < CNT_W'(MUL_LAST)) begin
        pp_d   = ah * bh;
        ppsh_d = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q == '0) begin
        if (!((state_q == S_R2) && (ax_q != 2'd0))) acc_d = '0;
      end else begin
        ppx   = {64'b0, pp_q} << {ppsh_q, 5'b0};
        acc_d = acc_q + ppx;
      end
    end

    // shared divider: load at cnt 0, one quotient bit per cycle after
    if (div_act) begin
      if (cnt_q == '0) begin
        hi     = div_q64 ? (div_src >> DIV_FULL_BITS) : (div_src >> DIV_SAT_BITS);
        dsat_d = (|hi[127:64]) || (hi[63:0] >= div_den);
        drem_d = hi[63:0];
        dnum_d = div_q64 ? div_src[63:0]
                         : (div_src[63:0] << (DIV_FULL_BITS - DIV_SAT_BITS));
        dquo_d = '0;
      end else begin
        dt65   = {drem_q, dnum_q[63]};
        if (dt65 >= {1'b0, div_den}) begin
          dt65   = dt65 - {1'b0, div_den};
          dquo_d = {dquo_q[62:0], 1'b1};
        end else begin
          dquo_d = {dquo_q[62:0], 1'b0};
        end
        drem_d = dt65[63:0];
        dnum_d = {dnum_q[62:0], 1'b0};
      end
    end

    case (state_q)
      S_DIFF: begin
        for (int i = 0; i < 3; i++) dd_d[i] = 35'(pb_q[i]) - 35'(pa_q[i]);
      end
      S_WRAP: begin
        for (int i = 0; i < 3; i++) begin
          half35 = $signed({4'b0, half_q[i]});
          box35  = $signed({4'b0, box_q[i]});
          if (dd_q[i] > half35) begin
            dd_d[i] = dd_q[i] - box35;
          end else if (dd_q[i] < -half35) begin
            dd_d[i] = dd_q[i] + box35;
          end
        end
      end
      S_CLAMP: begin
        for (int i = 0; i < 3; i++) begin
          cl = dd_q[i];
          if (cl > 35'sd2147483647) cl = 35'sd2147483647;
          if (cl < -35'sd2147483647) cl = -35'sd2147483647;
          ngv       = -cl;
          ad_d[i]   = cl[34] ? ngv[PRM_W-1:0] : cl[PRM_W-1:0];
          dneg_d[i] = cl[34];
        end
      end
      S_SQRT: begin
        if (cnt_q == '0) begin
          sx_d  = acc_q[63:0];
          r2_d  = acc_q[63:0];
          res_d = '0;
          one_d = 64'h4000_0000_0000_0000;
        end else begin
          sq_t = res_q + one_q;
          if (sx_q >= sq_t) begin
            sx_d  = sx_q - sq_t;
            res_d = (res_q >> 1) + one_q;
          end else begin
            res_d = res_q >> 1;
          end
          one_d = one_q >> 2;
        end
      end
      S_DT: begin
        r_d     = res_q[31:0];
        dt      = $signed({1'b0, res_q[31:0]}) - $signed({2'b0, req_q});
        dtneg_d = dt[32];
        adt_d   = dt[32] ? 32'(-dt) : dt[31:0];
        zero_d  = (res_q[31:0] == '0);
        for (int i = 0; i < 3; i++) frc_d[i] = '0;
      end
      S_E_MUL, S_H_SQ: begin
        if (mul_done) tmp_d = acc_d[63:0];
      end
      S_E_ACC: begin
        esh      = shift128(acc_q, SH_E);
        e        = (|esh[127:ENG_W]) ? MAX47 : esh[ENG_W-1:0];
        esum     = {1'b0, energy_q} + {1'b0, e};
        energy_d = esum[ENG_W] ? MAX47 : esum[ENG_W-1:0];
      end
      S_P2: begin
        if (mul_done) p2_d = {acc_d[62:0], 1'b0};
      end
      S_DE_SET: begin
        de_d = dtneg_q ? -$signed({1'b0, dres47[ENG_W-1:0]})
                       : $signed({1'b0, dres47[ENG_W-1:0]});
      end
      S_C_CALC: begin
        tk     = shift128({96'b0, k_q, 1'b0}, SH_DE);
        twok   = $signed(tk[63:0]);
        c      = twok - 64'(de_q);
        cneg_d = c[63];
        ac_d   = c[63] ? 64'(-c) : 64'(c);
      end
      S_H_ACC: begin
        sm = cneg_q ? -$signed(dres62) : $signed(dres62);
        h  = (sm + 64'(de_q)) <<< 1;
        hs = 64'(hacc_q[ax_q]) + h;
        if (hs > 64'sh7FFF_FFFF_FFFF) begin
          hacc_d[ax_q] = 48'sh7FFF_FFFF_FFFF;
        end else if (hs < -64'sh8000_0000_0000) begin
          hacc_d[ax_q] = -48'sh8000_0000_0000;
        end else begin
          hacc_d[ax_q] = hs[RES_W-1:0];
        end
      end
      S_F_SET: begin
        frc_d[ax_q] = (dtneg_q == dneg_q[ax_q]) ? -$signed({1'b0, dres47[ENG_W-1:0]})
                                               : $signed({1'b0, dres47[ENG_W-1:0]});
      end
      S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          od_d    = {1'b0, hacc_q[2], hacc_q[1], hacc_q[0], energy_q,
                     frc_q[2], frc_q[1], frc_q[0]};
          ouser_d = zero_q;
          olast_d = last_q;
          if (last_q) energy_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ax_q     <= '0;
      ov_q     <= 1'b0;
      energy_q <= '0;
      for (int i = 0; i < 3; i++) begin
        box_q[i]  <= '0;
        half_q[i] <= '0;
        hacc_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ax_q     <= ax_d;
      ov_q     <= ov_d;
      energy_q <= energy_d;
      for (int i = 0; i < 3; i++) begin
        box_q[i]  <= box_d[i];
        half_q[i] <= half_d[i];
        hacc_q[i] <= hacc_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pa_q[i]   <= pa_d[i];
      pb_q[i]   <= pb_d[i];
      dd_q[i]   <= dd_d[i];
      ad_q[i]   <= ad_d[i];
      dneg_q[i] <= dneg_d[i];
      frc_q[i]  <= frc_d[i];
    end
    req_q   <= req_d;
    k_q     <= k_d;
    last_q  <= last_d;
    pp_q    <= pp_d;
    ppsh_q  <= ppsh_d;
    acc_q   <= acc_d;
    sx_q    <= sx_d;
    res_q   <= res_d;
    one_q   <= one_d;
    r2_q    <= r2_d;
    r_q     <= r_d;
    adt_q   <= adt_d;
    dtneg_q <= dtneg_d;
    zero_q  <= zero_d;
    tmp_q   <= tmp_d;
    p2_q    <= p2_d;
    dnum_q  <= dnum_d;
    drem_q  <= drem_d;
    dquo_q  <= dquo_d;
    dsat_q  <= dsat_d;
    de_q    <= de_d;
    ac_q    <= ac_d;
    cneg_q  <= cneg_d;
    od_q    <= od_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
  end

endmodule
